>>> hw/rtl/bwaq_pkg.sv
`timescale 1ns / 1ps

package bwaq_pkg;

   // Fixed widths of the channel fields.
   localparam int VALUE_FIELD_BITS = 24;
   localparam int COUNT_FIELD_BITS = 3;

   // Quotient bits resolved per divider cycle.
   localparam int STEP_BITS = 8;

   // Operation codes on the request channel.
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // Status codes on the response channel.
   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_EMPTY = 1'b1;

   typedef struct packed {
      logic                        operation;
      logic [VALUE_FIELD_BITS-1:0] sample_value;
   } req_payload_type;

   typedef struct packed {
      logic [VALUE_FIELD_BITS-1:0] window_mean;
      logic [VALUE_FIELD_BITS-1:0] removed_value;
      logic                        status;
      logic [COUNT_FIELD_BITS-1:0] held_count;
   } rsp_payload_type;

   typedef enum logic {
      CMD_INSERT,
      CMD_REMOVE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                kind;
      logic [VALUE_FIELD_BITS-1:0] value;
   } cmd_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_UPDATE,
      BACK_DIVIDE,
      BACK_RESPOND
   } back_state_type;

endpackage

>>> hw/rtl/bwaq_if.sv
`timescale 1ns / 1ps

interface bwaq_req_if;
   logic                      valid;
   logic                      ready;
   bwaq_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bwaq_rsp_if;
   logic                      valid;
   logic                      ready;
   bwaq_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/bwaq_front.sv
`timescale 1ns / 1ps

// Accepts request beats, turns them into commands and holds them in a
// two-entry queue until the back end takes them.
module bwaq_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bwaq_pkg::req_payload_type req_payload,
   output logic                      cmd_valid,
   input  logic                      cmd_ready,
   output bwaq_pkg::cmd_type         cmd
);

   bwaq_pkg::cmd_type entry_ff [2];
   bwaq_pkg::cmd_type entry_in;
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        fill_ff;
   logic [1:0]        fill_in;
   logic              push;
   logic              pop;

   assign req_ready = (fill_ff != 2'd2);
   assign cmd_valid = (fill_ff != 2'd0);
   assign cmd       = entry_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      entry_in.kind  = (req_payload.operation == bwaq_pkg::OP_REMOVE) ?
                       bwaq_pkg::CMD_REMOVE : bwaq_pkg::CMD_INSERT;
      entry_in.value = req_payload.sample_value;
      wr_ptr_in      = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in      = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      priority case (1'b1)
         push && !pop: fill_in = fill_ff + 2'd1;
         pop && !push: fill_in = fill_ff - 2'd1;
         default:      fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

>>> hw/rtl/bwaq_div.sv
`timescale 1ns / 1ps

// Restoring divider that resolves STEP_BITS quotient bits per cycle.
// The remainder fits the divisor width since it stays below the divisor.
module bwaq_div #(
   parameter int DW = 32,
   parameter int CW = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [CW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient,
   output logic [CW-1:0] remainder
);

   localparam int STEPS = DW / bwaq_pkg::STEP_BITS;
   localparam int SCW   = (STEPS > 1) ? $clog2(STEPS) : 1;

   logic           busy_ff;
   logic           busy_in;
   logic           done_ff;
   logic           done_in;
   logic [SCW-1:0] step_ff;
   logic [SCW-1:0] step_in;
   logic [DW-1:0]  work_ff;
   logic [DW-1:0]  work_in;
   logic [CW-1:0]  rem_ff;
   logic [CW-1:0]  rem_in;
   logic [CW-1:0]  div_ff;
   logic [CW-1:0]  div_in;

   assign done      = done_ff;
   assign quotient  = work_ff;
   assign remainder = rem_ff;

   always_comb begin
      logic [CW:0]   r;
      logic [DW-1:0] w;
      r = {1'b0, rem_ff};
      w = work_ff;
      for (int i = 0; i < bwaq_pkg::STEP_BITS; i++) begin
         r = {r[CW-1:0], w[DW-1]};
         w = {w[DW-2:0], 1'b0};
         if (r >= {1'b0, div_ff}) begin
            r    = r - {1'b0, div_ff};
            w[0] = 1'b1;
         end
      end

      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = SCW'(STEPS - 1);
         work_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         work_in = w;
         rem_in  = r[CW-1:0];
         step_in = step_ff - SCW'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

endmodule

>>> hw/rtl/bwaq_back.sv
`timescale 1ns / 1ps

// Executes one command at a time: reads the oldest entry, updates the
// circular window and running total, after an insert divides the total by
// the count, and holds the response until it is taken.
module bwaq_back #(
   parameter int WINDOW     = 5,
   parameter int VALUE_BITS = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      cmd_valid,
   output logic                      cmd_ready,
   input  bwaq_pkg::cmd_type         cmd,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bwaq_pkg::rsp_payload_type rsp_payload
);

   localparam int FB  = bwaq_pkg::VALUE_FIELD_BITS;
   localparam int HB  = bwaq_pkg::COUNT_FIELD_BITS;
   localparam int CW  = $clog2(WINDOW + 1);
   localparam int PW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SW  = CW + 1;
   localparam int TW  = VALUE_BITS + CW;
   localparam int DW  = ((TW + bwaq_pkg::STEP_BITS - 1) / bwaq_pkg::STEP_BITS) *
                        bwaq_pkg::STEP_BITS;

   localparam logic [PW-1:0] LAST_SLOT  = PW'(WINDOW - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(WINDOW);
   localparam logic [SW-1:0] WINDOW_SUM = SW'(WINDOW);

   bwaq_pkg::back_state_type state_ff;
   bwaq_pkg::back_state_type state_in;

   bwaq_pkg::cmd_kind_type   kind_ff;
   bwaq_pkg::cmd_kind_type   kind_in;
   logic [FB-1:0]            value_ff;
   logic [FB-1:0]            value_in;

   logic [VALUE_BITS-1:0]    window_mem [WINDOW];
   logic [VALUE_BITS-1:0]    rd_data_ff;
   logic                     mem_we;
   logic [PW-1:0]            wr_addr;

   logic [PW-1:0]            oldest_ff;
   logic [PW-1:0]            oldest_in;
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic [TW-1:0]            total_ff;
   logic [TW-1:0]            total_in;

   bwaq_pkg::rsp_payload_type rsp_ff;
   bwaq_pkg::rsp_payload_type rsp_in;
   logic                      load_rsp;

   logic                     div_start;
   logic                     div_done;
   logic [DW-1:0]            div_quo;
   logic [CW-1:0]            div_rem;

   // Width adjustments between internal and field widths.
   logic [VALUE_BITS+FB-1:0] value_ext;
   logic [VALUE_BITS-1:0]    value_v;
   logic [TW+VALUE_BITS-1:0] value_tot_ext;
   logic [TW+VALUE_BITS-1:0] old_tot_ext;
   logic [TW-1:0]            value_tot;
   logic [TW-1:0]            old_tot;
   logic [VALUE_BITS+FB-1:0] old_field_ext;
   logic [CW-1:0]            count_dec;
   logic [CW+HB-1:0]         held_dec_ext;
   logic [CW+HB-1:0]         held_cur_ext;
   logic [DW+TW-1:0]         dividend_ext;
   logic [DW-1:0]            mean_round;
   logic [DW+FB-1:0]         mean_ext;
   logic                     round_up;

   logic                     full;
   logic [PW-1:0]            next_oldest;
   logic [SW-1:0]            tail_sum;
   logic [SW-1:0]            tail_wrap;

   assign value_ext     = {{VALUE_BITS{1'b0}}, value_ff};
   assign value_v       = value_ext[VALUE_BITS-1:0];
   assign value_tot_ext = {{TW{1'b0}}, value_v};
   assign value_tot     = value_tot_ext[TW-1:0];
   assign old_tot_ext   = {{TW{1'b0}}, rd_data_ff};
   assign old_tot       = old_tot_ext[TW-1:0];
   assign old_field_ext = {{FB{1'b0}}, rd_data_ff};
   assign count_dec     = count_ff - CW'(1);
   assign held_dec_ext  = {{HB{1'b0}}, count_dec};
   assign held_cur_ext  = {{HB{1'b0}}, count_ff};
   assign dividend_ext  = {{DW{1'b0}}, total_in};

   // Round up only when twice the remainder exceeds the count.
   assign round_up   = ({div_rem, 1'b0} > {1'b0, count_ff});
   assign mean_round = div_quo + {{(DW-1){1'b0}}, round_up};
   assign mean_ext   = {{FB{1'b0}}, mean_round};

   assign full        = (count_ff == FULL_COUNT);
   assign next_oldest = (oldest_ff == LAST_SLOT) ? '0 : oldest_ff + PW'(1);
   assign tail_sum    = {{(SW-PW){1'b0}}, oldest_ff} + {1'b0, count_ff};
   assign tail_wrap   = (tail_sum >= WINDOW_SUM) ? tail_sum - WINDOW_SUM : tail_sum;

   assign rsp_valid   = (state_ff == bwaq_pkg::BACK_RESPOND);
   assign rsp_payload = rsp_ff;

   bwaq_div #(
      .DW (DW),
      .CW (CW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (dividend_ext[DW-1:0]),
      .divisor   (count_in),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Next state.
   always_comb begin
      unique case (state_ff)
         bwaq_pkg::BACK_IDLE:
            state_in = cmd_valid ? bwaq_pkg::BACK_UPDATE : bwaq_pkg::BACK_IDLE;
         bwaq_pkg::BACK_UPDATE:
            state_in = (kind_ff == bwaq_pkg::CMD_INSERT) ?
                       bwaq_pkg::BACK_DIVIDE : bwaq_pkg::BACK_RESPOND;
         bwaq_pkg::BACK_DIVIDE:
            state_in = div_done ? bwaq_pkg::BACK_RESPOND : bwaq_pkg::BACK_DIVIDE;
         bwaq_pkg::BACK_RESPOND:
            state_in = rsp_ready ? bwaq_pkg::BACK_IDLE : bwaq_pkg::BACK_RESPOND;
      endcase
   end

   // Outputs and datapath controls.
   always_comb begin
      cmd_ready = 1'b0;
      kind_in   = kind_ff;
      value_in  = value_ff;
      mem_we    = 1'b0;
      wr_addr   = oldest_ff;
      oldest_in = oldest_ff;
      count_in  = count_ff;
      total_in  = total_ff;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      rsp_in    = '0;
      unique case (state_ff)
         bwaq_pkg::BACK_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               kind_in  = cmd.kind;
               value_in = cmd.value;
            end
         end
         bwaq_pkg::BACK_UPDATE: begin
            if (kind_ff == bwaq_pkg::CMD_INSERT) begin
               mem_we    = 1'b1;
               div_start = 1'b1;
               if (full) begin
                  // The new value takes the slot of the dropped one.
                  wr_addr   = oldest_ff;
                  oldest_in = next_oldest;
                  total_in  = total_ff - old_tot + value_tot;
               end else begin
                  wr_addr  = tail_wrap[PW-1:0];
                  count_in = count_ff + CW'(1);
                  total_in = total_ff + value_tot;
               end
            end else if (count_ff == '0) begin
               load_rsp      = 1'b1;
               rsp_in.status = bwaq_pkg::STATUS_EMPTY;
            end else begin
               oldest_in            = next_oldest;
               count_in             = count_dec;
               total_in             = total_ff - old_tot;
               load_rsp             = 1'b1;
               rsp_in.removed_value = old_field_ext[FB-1:0];
               rsp_in.status        = bwaq_pkg::STATUS_DONE;
               rsp_in.held_count    = held_dec_ext[HB-1:0];
            end
         end
         bwaq_pkg::BACK_DIVIDE: begin
            if (div_done) begin
               load_rsp           = 1'b1;
               rsp_in.window_mean = mean_ext[FB-1:0];
               rsp_in.status      = bwaq_pkg::STATUS_DONE;
               rsp_in.held_count  = held_cur_ext[HB-1:0];
            end
         end
         bwaq_pkg::BACK_RESPOND: begin
            cmd_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= bwaq_pkg::BACK_IDLE;
         oldest_ff <= '0;
         count_ff  <= '0;
         total_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
         total_ff  <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   // Window storage: one write port, one registered read of the oldest slot.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         window_mem[wr_addr] <= value_v;
      end
      rd_data_ff <= window_mem[oldest_ff];
   end

endmodule

>>> hw/rtl/bounded_window_average_queue.sv
`timescale 1ns / 1ps

// Sliding window average queue.
// The request channel carries one command per beat: insert a sample or
// remove the oldest one. The response channel returns exactly one beat per
// request, in order: the rounded mean after an insert, the popped value
// after a remove, an empty status for a remove on an empty window, and the
// count of held values.
// A two-entry command queue sits in front of the execution engine, so up to
// two requests are taken while a response waits; the request side stalls
// only when that queue is full.
// A remove passes through the command queue and the update state before
// its response is valid; an insert also waits in the divide state while the
// divider works through the running total in 8-bit steps.
// Commands execute one at a time: the engine takes the next command only
// after the receiver has taken the response to the last one, and an insert
// holds the engine longer than a remove because of the running-total divider.
// A stalled response holds its beat unchanged and the engine waits.
// Reset empties the window and the command queue at the next rising edge.
module bounded_window_average_queue #(
   parameter int WINDOW     = 5,
   parameter int VALUE_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   bwaq_req_if.sink          req_chan,
   bwaq_rsp_if.source        rsp_chan
);

   // Command hand-off between the front end and the execution engine.
   logic              cmd_valid;
   logic              cmd_ready;
   bwaq_pkg::cmd_type cmd;

   bwaq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_payload (req_chan.payload),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd)
   );

   // The engine owns the window storage, the running total and the divider.
   bwaq_back #(
      .WINDOW     (WINDOW),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_payload (rsp_chan.payload)
   );

endmodule

>>> hw/rtl/bwaq_checker.sv
`timescale 1ns / 1ps

module bwaq_checker #(
   parameter int WINDOW = 5
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input bwaq_pkg::rsp_payload_type rsp_payload
);

   // Requests taken whose response beat has not gone out yet.
   logic [2:0] pending_ff;
   logic [2:0] pending_in;
   logic       req_fire;
   logic       rsp_fire;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff + {2'b00, req_fire} - {2'b00, rsp_fire};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("response beat changed while stalled");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("response beat without a pending request");

   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      pending_ff == 3'd3 |-> !req_ready)
      else $error("request taken beyond queue and engine capacity");

   a_empty_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == bwaq_pkg::STATUS_EMPTY |->
         rsp_payload.window_mean == '0 && rsp_payload.removed_value == '0 &&
         rsp_payload.held_count == '0)
      else $error("empty status with nonzero fields");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_payload.held_count) <= WINDOW)
      else $error("held count beyond window size");

endmodule

bind bounded_window_average_queue bwaq_checker #(
   .WINDOW (WINDOW)
) u_bwaq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

>>> dv/bwaq_checker.sv
`timescale 1ns / 1ps

module bwaq_tb_checker #(
   parameter int WINDOW = 5
) (
   input  logic clock,
   input  logic reset,
   bwaq_req_if  req_mon,
   bwaq_rsp_if  rsp_mon,
   output int   mismatch_count,
   output int   results_waiting,
   output int   results_checked,
   output int   full_inserts,
   output int   empty_removes
);

   // Shadow copy of the window: circular store, oldest index, fill and sum.
   logic [bwaq_pkg::VALUE_FIELD_BITS-1:0] window_vals [WINDOW];
   int unsigned                           head_slot;
   int unsigned                           held;
   logic [26:0]                           window_sum;

   bwaq_pkg::rsp_payload_type             expected_beats [$];

   task automatic report_mismatch(input string what);
      $display("[%0t] bwaq_tb_checker mismatch: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic logic [bwaq_pkg::VALUE_FIELD_BITS-1:0] drop_oldest();
      logic [bwaq_pkg::VALUE_FIELD_BITS-1:0] oldest;
      oldest     = window_vals[head_slot];
      window_sum = window_sum - oldest;
      head_slot  = (head_slot + 1) % WINDOW;
      held       = held - 1;
      return oldest;
   endfunction

   // Applies one command to the shadow window and returns the beat it causes.
   function automatic bwaq_pkg::rsp_payload_type predict_window(
         input bwaq_pkg::req_payload_type cmd);
      bwaq_pkg::rsp_payload_type beat;
      logic [26:0]               quot;
      logic [26:0]               rem;
      beat = '0;
      beat.status = bwaq_pkg::STATUS_DONE;
      if (cmd.operation == bwaq_pkg::OP_INSERT) begin
         if (held >= WINDOW) begin
            void'(drop_oldest());
            full_inserts++;
         end
         window_vals[(head_slot + held) % WINDOW] = cmd.sample_value;
         held       = held + 1;
         window_sum = window_sum + cmd.sample_value;
         quot = window_sum / held;
         rem  = window_sum % held;
         // Round up only when the leftover fraction is above one half.
         beat.window_mean = ((rem << 1) > held) ? quot + 1 : quot;
      end else if (held == 0) begin
         beat.status = bwaq_pkg::STATUS_EMPTY;
         empty_removes++;
      end else begin
         beat.removed_value = drop_oldest();
      end
      beat.held_count = held[bwaq_pkg::COUNT_FIELD_BITS-1:0];
      return beat;
   endfunction

   task automatic compare_beat(input bwaq_pkg::rsp_payload_type got,
                               input bwaq_pkg::rsp_payload_type want);
      if (got.window_mean !== want.window_mean)
         report_mismatch($sformatf("window_mean %h, predicted %h",
                                   got.window_mean, want.window_mean));
      if (got.removed_value !== want.removed_value)
         report_mismatch($sformatf("removed_value %h, predicted %h",
                                   got.removed_value, want.removed_value));
      if (got.status !== want.status)
         report_mismatch($sformatf("status %b, predicted %b", got.status, want.status));
      if (got.held_count !== want.held_count)
         report_mismatch($sformatf("held_count %0d, predicted %0d",
                                   got.held_count, want.held_count));
   endtask

   initial begin
      mismatch_count  = 0;
      results_waiting = 0;
      results_checked = 0;
      full_inserts    = 0;
      empty_removes   = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         foreach (window_vals[i]) window_vals[i] = '0;
         head_slot  = 0;
         held       = 0;
         window_sum = '0;
         expected_beats.delete();
      end else begin
         // A response can never belong to a request taken at the same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_beats.size() == 0) begin
               report_mismatch("response beat with no request outstanding");
            end else begin
               compare_beat(rsp_mon.payload, expected_beats.pop_front());
               results_checked++;
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_beats.push_back(predict_window(req_mon.payload));
      end
      results_waiting = expected_beats.size();
   end

endmodule

>>> dv/tb_bounded_window_average_queue.sv
`timescale 1ns / 1ps

// Top of the window average queue bench. This module only makes stimulus and
// gives the verdict; the checker beside the block watches both channels,
// keeps its own model of the window and compares every response beat.
module tb_bounded_window_average_queue;

   localparam int WINDOW       = 5;
   localparam int RANDOM_ITEMS = 500;
   localparam int DRAIN_CYCLES = 24;

   // The receiver refuses every beat over this window of cycles, so the
   // command queue fills and the request side has to stall.
   localparam int HOLD_START  = 600;
   localparam int HOLD_CYCLES = 120;
   // Receiver takes every beat in this window of cycles.
   localparam int RX_QUIET_START = 1500;
   localparam int RX_QUIET_END   = 2300;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } mix_type;

   logic clock;
   logic reset;
   logic sender_quiet;

   int   mismatch_count;
   int   results_waiting;
   int   results_checked;
   int   full_inserts;
   int   empty_removes;

   bwaq_req_if req_chan ();
   bwaq_rsp_if rsp_chan ();

   bounded_window_average_queue #(
      .WINDOW     (WINDOW),
      .VALUE_BITS (bwaq_pkg::VALUE_FIELD_BITS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bwaq_tb_checker #(
      .WINDOW (WINDOW)
   ) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_chan),
      .rsp_mon         (rsp_chan),
      .mismatch_count  (mismatch_count),
      .results_waiting (results_waiting),
      .results_checked (results_checked),
      .full_inserts    (full_inserts),
      .empty_removes   (empty_removes)
   );

   initial clock = 1'b0;
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Generous ceiling: a correct run needs well under a tenth of this.
   initial begin
      #400_000;
      $display("bounded_window_average_queue test failed");
      $finish;
   end

   // Sample values lean toward the edges of the field and toward small
   // numbers, which is where the round-half-down rule shows up.
   function automatic logic [bwaq_pkg::VALUE_FIELD_BITS-1:0] pick_sample();
      logic [bwaq_pkg::VALUE_FIELD_BITS-1:0] value;
      case ($urandom_range(5))
         0: value = '0;
         1: value = '1;
         2, 3: value = 24'($urandom_range(15));
         4: value = 24'($urandom);
         default: value = {1'b1, 23'($urandom)};
      endcase
      return value;
   endfunction

   // Called at a falling edge. Offers one beat, waits for it to be taken and
   // returns at the falling edge after the accepting rising edge, with valid
   // still high so a following beat can go out back to back.
   task automatic send_item(input logic op,
                            input logic [bwaq_pkg::VALUE_FIELD_BITS-1:0] value);
      int gap;
      if (!sender_quiet && $urandom_range(99) < 6) begin
         gap = $urandom_range(1, 4);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid                <= 1'b1;
      req_chan.payload.operation    <= op;
      req_chan.payload.sample_value <= value;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Receiver: counts its own cycles after reset. Mostly ready, with short
   // random refusals, one long hold-off and one stretch with no refusals.
   initial begin
      int cycle;
      cycle = 0;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES)
            rsp_chan.ready <= 1'b0;
         else if (cycle >= RX_QUIET_START && cycle < RX_QUIET_END)
            rsp_chan.ready <= 1'b1;
         else
            rsp_chan.ready <= ($urandom_range(99) >= 6);
         cycle++;
         @(negedge clock);
      end
   end

   // Stimulus and verdict.
   initial begin
      mix_type mix;
      int      roll;
      logic    op;

      reset                         = 1'b1;
      sender_quiet                  = 1'b0;
      req_chan.valid                = 1'b0;
      req_chan.payload.operation    = bwaq_pkg::OP_INSERT;
      req_chan.payload.sample_value = '0;
      mix                           = MIX_EVEN;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed opening. A remove on an empty window must flag empty and
      // leave everything at zero; the sample field of a remove is ignored.
      send_item(bwaq_pkg::OP_REMOVE, '1);
      send_item(bwaq_pkg::OP_INSERT, 24'd0);
      // Sum 1 over 2 values is an exact half and must round down.
      send_item(bwaq_pkg::OP_INSERT, 24'd1);
      // Sum 5 over 3 values leaves two thirds and must round up.
      send_item(bwaq_pkg::OP_INSERT, 24'd4);
      send_item(bwaq_pkg::OP_INSERT, '1);
      send_item(bwaq_pkg::OP_INSERT, '1);
      // The window is full now, so each further insert evicts the oldest.
      send_item(bwaq_pkg::OP_INSERT, '1);
      send_item(bwaq_pkg::OP_INSERT, '1);
      send_item(bwaq_pkg::OP_INSERT, '1);
      send_item(bwaq_pkg::OP_INSERT, 24'hAAAAAA);
      send_item(bwaq_pkg::OP_INSERT, 24'h555555);
      // Empty the window completely, including the very last value.
      repeat (WINDOW) send_item(bwaq_pkg::OP_REMOVE, 24'h5A5A5A);
      send_item(bwaq_pkg::OP_REMOVE, '0);
      // A single value that goes in and comes straight back out.
      send_item(bwaq_pkg::OP_INSERT, 24'h800000);
      send_item(bwaq_pkg::OP_REMOVE, '1);
      send_item(bwaq_pkg::OP_REMOVE, '0);
      // Sum 3 over 2 values is another exact half.
      send_item(bwaq_pkg::OP_INSERT, 24'd3);
      send_item(bwaq_pkg::OP_INSERT, 24'd0);
      send_item(bwaq_pkg::OP_INSERT, 24'd0);
      send_item(bwaq_pkg::OP_INSERT, 24'hFFFFFE);

      // Random part. The command mix drifts between filling, draining and an
      // even blend so the fill level sweeps the whole range many times.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 32 == 0)
            mix = mix_type'($urandom_range(2));
         sender_quiet = (n >= 200 && n < 320);
         roll = $urandom_range(99);
         case (mix)
            MIX_FILL:  op = (roll < 80) ? bwaq_pkg::OP_INSERT : bwaq_pkg::OP_REMOVE;
            MIX_DRAIN: op = (roll < 30) ? bwaq_pkg::OP_INSERT : bwaq_pkg::OP_REMOVE;
            default:   op = (roll < 55) ? bwaq_pkg::OP_INSERT : bwaq_pkg::OP_REMOVE;
         endcase
         send_item(op, pick_sample());
      end
      req_chan.valid <= 1'b0;

      // Wait for every outstanding response, then linger a little longer so a
      // stray extra beat would still be caught.
      while (results_waiting != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Checked %0d response beats over directed and random command streams.",
               results_checked);
      $display("Saw %0d inserts into a full window and %0d removes on an empty one.",
               full_inserts, empty_removes);
      if (mismatch_count == 0)
         $display("bounded_window_average_queue test passed");
      else
         $display("bounded_window_average_queue test failed");
      $finish;
   end

endmodule
